### hw/rtl/assert_macros.svh
// assertion macros for the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising edge, off while reset is low
`define HVD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// next-cycle implication built on the macro above
`define HVD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  `HVD_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

### hw/rtl/hvd_pkg.sv
// shared constants, state type and arctangent table for the trip distance block
// no dependencies
package hvd_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int CORD_N   = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int MUL_W    = 40;
  localparam int DIV_W    = 32;
  localparam int SQ_STEPS = 31;

  localparam logic [31:0]        PI_Q30     = 32'd3373259426;
  localparam logic signed [35:0] GAIN_Q30   = 36'sd652032874;
  localparam logic signed [79:0] HALF_Q30   = 80'sd536870912;
  localparam logic [30:0]        ONE_Q30    = 31'd1073741824;
  localparam logic signed [34:0] S_DEG360   = 35'sd3600000000;
  localparam logic signed [34:0] S_DEG180   = 35'sd1800000000;
  localparam logic [31:0]        DEG360     = 32'd3600000000;
  localparam logic [31:0]        DEG180     = 32'd1800000000;
  localparam logic [31:0]        DEG90      = 32'd900000000;

  localparam logic [22:0] RADIUS_RST = 23'd6371000;
  localparam logic [47:0] THRESH_RST = 48'd10000;

  // configuration register indexes
  localparam logic [1:0] CFG_RADIUS = 2'd0;
  localparam logic [1:0] CFG_THRESH = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_MUL, ST_RDIV0, ST_RDIV, ST_CORD, ST_CDONE, ST_SQD,
    ST_BC, ST_HD, ST_H, ST_SQRT, ST_ANG, ST_SEG, ST_OUT
  } hvd_state_t;

  // atan(2^-i) in Q2.30
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0:  atan_q30 = 32'h3243F6A8;
      5'd1:  atan_q30 = 32'h1DAC6705;
      5'd2:  atan_q30 = 32'h0FADBAFC;
      5'd3:  atan_q30 = 32'h07F56EA6;
      5'd4:  atan_q30 = 32'h03FEAB76;
      5'd5:  atan_q30 = 32'h01FFD55B;
      5'd6:  atan_q30 = 32'h00FFFAAA;
      5'd7:  atan_q30 = 32'h007FFF55;
      5'd8:  atan_q30 = 32'h003FFFEA;
      5'd9:  atan_q30 = 32'h001FFFFD;
      5'd10: atan_q30 = 32'h000FFFFF;
      5'd11: atan_q30 = 32'h0007FFFF;
      5'd12: atan_q30 = 32'h0003FFFF;
      5'd13: atan_q30 = 32'h0001FFFF;
      5'd14: atan_q30 = 32'h0000FFFF;
      5'd15: atan_q30 = 32'h00007FFF;
      5'd16: atan_q30 = 32'h00003FFF;
      5'd17: atan_q30 = 32'h00001FFF;
      5'd18: atan_q30 = 32'h00000FFF;
      5'd19: atan_q30 = 32'h000007FF;
      5'd20: atan_q30 = 32'h000003FF;
      5'd21: atan_q30 = 32'h000001FF;
      5'd22: atan_q30 = 32'h000000FF;
      5'd23: atan_q30 = 32'h0000007F;
      5'd24: atan_q30 = 32'h0000003F;
      5'd25: atan_q30 = 32'h0000001F;
      5'd26: atan_q30 = 32'h0000000F;
      5'd27: atan_q30 = 32'h00000008;
      5'd28: atan_q30 = 32'h00000004;
      5'd29: atan_q30 = 32'h00000002;
      5'd30: atan_q30 = 32'h00000001;
      default: atan_q30 = 32'h00000000;
    endcase
  endfunction

endpackage

### hw/rtl/haversine_trip_distance.sv
// haversine great-circle trip distance: serial multiplier, divider, cordic, sqrt
// depends on hvd_pkg
//
// channel   dir  fields (lsb first)
// in_       in   start_lat 31, start_lon 32, end_lat 31, end_lon 32
// out_      out  segment_cm 32, trip_total_cm 48, alert 1
// cfg_      in   0 earth_radius_m 23, 1 alert_threshold_cm 48
//
// one point pair runs from accept to result through the shift-add multiplier
// (used nine times), the divider, the 24-step cordic (five passes) and the
// 31-step square root (two passes)
// one pair is in work at a time; in_tready is high only when idle
// a finished result sits in the output register while the next pair runs
// reset (rst_n low, synchronous) clears the trip total, alert, output valid and state, and reloads the configuration
module haversine_trip_distance import hvd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // start_lat, start_lon, end_lat, end_lon, zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [87:0]  out_tdata,  // segment_cm, trip_total_cm, alert, zero pad
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [47:0]  cfg_wdata
);

  hvd_state_t state_r, state_nxt, mret_r;

  logic signed [31:0] lat1_r, lon1_r, lat2_r, lon2_r;
  logic [1:0]  idx_r;
  logic        half_r, neg_r, cvec_r, sqsel_r;
  logic [5:0]  cnt_r;
  logic [22:0] radius_r;
  logic [47:0] thresh_r, total_r;
  logic        alert_r;

  logic signed [79:0] mcand_r, macc_r;
  logic [39:0] mplier_r;
  logic        mneg_r;
  logic [31:0] drem_r, dlo_r;
  logic signed [35:0] cx_r, cy_r, cz_r;
  logic signed [35:0] a_r, d_r, c1_r, c2_r;
  logic [30:0] h_r;
  logic [60:0] sqv_r, sqr_r;
  logic [60:0] sy_r;
  logic [31:0] seg_r;
  logic        out_tvalid_r;
  logic [87:0] out_tdata_r;

  // launch controls for the shared units
  logic mul_go, cord_go, cord_vec, sq_go;
  logic signed [39:0] mul_a, mul_b;
  hvd_state_t mul_ret;
  logic signed [35:0] cx0, cy0, cz0;
  logic [60:0] sq_v0;

  // angle preparation: wrapped difference or latitude fold
  logic signed [34:0] dif, w1, w2, lat_sel, labs;
  logic [31:0] m_prep;
  logic        neg_prep;

  always_comb begin
    dif = idx_r[0] ? (35'(lon2_r) - 35'(lon1_r)) : (35'(lat2_r) - 35'(lat1_r));
    if (dif >= S_DEG360)       w1 = dif - S_DEG360;
    else if (dif <= -S_DEG360) w1 = dif + S_DEG360;
    else                       w1 = dif;
    if (w1 >= S_DEG180)        w2 = w1 - S_DEG360;
    else if (w1 < -S_DEG180)   w2 = w1 + S_DEG360;
    else                       w2 = w1;
    lat_sel = idx_r[0] ? 35'(lat2_r) : 35'(lat1_r);
    labs = lat_sel[34] ? -lat_sel : lat_sel;
    neg_prep = 1'b0;
    if (!idx_r[1]) begin
      m_prep = w2[34] ? 32'(-w2) : 32'(w2);
    end else if (labs[31:0] > DEG90) begin
      m_prep = DEG180 - labs[31:0];
      neg_prep = 1'b1;
    end else begin
      m_prep = labs[31:0];
    end
  end

  // multiplier product and q30 rounding
  logic signed [79:0] mprod, mrf;
  logic signed [35:0] mrnd;
  assign mprod = mneg_r ? -macc_r : macc_r;
  assign mrf   = mprod + HALF_Q30;
  assign mrnd  = mrf[65:30];

  // divider step
  logic [31:0] ddiv;
  logic [32:0] dt;
  logic        dq;
  logic [63:0] dnum;
  assign ddiv = half_r ? DEG360 : DEG180;
  assign dt   = {drem_r, dlo_r[31]};
  assign dq   = dt >= {1'b0, ddiv};
  assign dnum = mprod[63:0] + {33'd0, ddiv[31:1]};

  // cordic step, rotation and vectoring share the same update
  logic c_up;
  logic signed [35:0] cxs, cys, catv, cx_s, cy_s, cz_s;
  always_comb begin
    c_up = cvec_r ? cy_r[35] : !cz_r[35];
    cxs  = cx_r >>> cnt_r[4:0];
    cys  = cy_r >>> cnt_r[4:0];
    catv = $signed({4'd0, atan_q30(cnt_r[4:0])});
    cx_s = c_up ? cx_r - cys : cx_r + cys;
    cy_s = c_up ? cy_r + cxs : cy_r - cxs;
    cz_s = c_up ? cz_r - catv : cz_r + catv;
  end

  // square root step
  logic [5:0]  sq_sh;
  logic [60:0] sq_bit, sq_t, sqv_s, sqr_s;
  logic        sq_ge;
  always_comb begin
    sq_sh  = 6'd60 - {cnt_r[4:0], 1'b0};
    sq_bit = 61'd1 << sq_sh;
    sq_t   = sqr_r + sq_bit;
    sq_ge  = sqv_r >= sq_t;
    sqv_s  = sq_ge ? sqv_r - sq_t : sqv_r;
    sqr_s  = sq_ge ? (sqr_r >> 1) + sq_bit : sqr_r >> 1;
  end

  // haversine sum with clamp to [0, 1]
  logic signed [36:0] hsum;
  logic [30:0] h_clamp;
  always_comb begin
    hsum = 37'(a_r) + 37'(mrnd);
    if (hsum[36])                      h_clamp = '0;
    else if (hsum > 37'(ONE_Q30))      h_clamp = ONE_Q30;
    else                               h_clamp = hsum[30:0];
  end

  // radius times 100 and doubled angle
  logic [29:0] r100;
  logic [35:0] ang2;
  assign r100 = {1'b0, radius_r, 6'd0} + {2'b0, radius_r, 5'd0} + {5'd0, radius_r, 2'd0};
  assign ang2 = cz_r[35] ? '0 : {cz_r[34:0], 1'b0};

  // running total with saturation
  logic [48:0] tot_sum;
  logic [47:0] tot_sat;
  assign tot_sum = {1'b0, total_r} + {17'd0, seg_r};
  assign tot_sat = tot_sum[48] ? '1 : tot_sum[47:0];

  // next state and unit launches
  always_comb begin
    state_nxt = state_r;
    mul_go = 1'b0; mul_a = '0; mul_b = '0; mul_ret = ST_IDLE;
    cord_go = 1'b0; cord_vec = 1'b0; cx0 = '0; cy0 = '0; cz0 = '0;
    sq_go = 1'b0; sq_v0 = '0;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_PREP;
      ST_PREP: begin
        mul_go = 1'b1;
        mul_a = $signed({8'd0, PI_Q30});
        mul_b = $signed({8'd0, m_prep});
        mul_ret = ST_RDIV0;
        state_nxt = ST_MUL;
      end
      ST_MUL: if (cnt_r == 6'(MUL_W - 1)) state_nxt = mret_r;
      ST_RDIV0: state_nxt = ST_RDIV;
      ST_RDIV: begin
        if (cnt_r == 6'(DIV_W - 1)) begin
          cord_go = 1'b1;
          cx0 = GAIN_Q30;
          cz0 = $signed({4'd0, dlo_r[30:0], dq});
          state_nxt = ST_CORD;
        end
      end
      ST_CORD: if (cnt_r == 6'(CORD_N - 1)) state_nxt = ST_CDONE;
      ST_CDONE: begin
        if (cvec_r) begin
          state_nxt = ST_ANG;
        end else if (!idx_r[1]) begin
          mul_go = 1'b1;
          mul_a = 40'(cy_r);
          mul_b = 40'(cy_r);
          mul_ret = ST_SQD;
          state_nxt = ST_MUL;
        end else if (idx_r[0]) begin
          state_nxt = ST_BC;
        end else begin
          state_nxt = ST_PREP;
        end
      end
      ST_SQD: state_nxt = ST_PREP;
      ST_BC: begin
        mul_go = 1'b1;
        mul_a = 40'(c1_r);
        mul_b = 40'(c2_r);
        mul_ret = ST_HD;
        state_nxt = ST_MUL;
      end
      ST_HD: begin
        mul_go = 1'b1;
        mul_a = 40'(mrnd);
        mul_b = 40'(d_r);
        mul_ret = ST_H;
        state_nxt = ST_MUL;
      end
      ST_H: begin
        sq_go = 1'b1;
        sq_v0 = {h_clamp, 30'd0};
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        if (cnt_r == 6'(SQ_STEPS - 1)) begin
          if (!sqsel_r) begin
            sq_go = 1'b1;
            sq_v0 = {ONE_Q30 - h_r, 30'd0};
          end else begin
            cord_go = 1'b1;
            cord_vec = 1'b1;
            cx0 = $signed(sqr_s[35:0]);
            cy0 = $signed(sy_r[35:0]);
            state_nxt = ST_CORD;
          end
        end
      end
      ST_ANG: begin
        mul_go = 1'b1;
        mul_a = $signed({10'd0, r100});
        mul_b = $signed({4'd0, ang2});
        mul_ret = ST_SEG;
        state_nxt = ST_MUL;
      end
      ST_SEG: state_nxt = ST_OUT;
      ST_OUT: if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control state: configuration, total, alert, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r     <= RADIUS_RST;
      thresh_r     <= THRESH_RST;
      total_r      <= '0;
      alert_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_addr == CFG_RADIUS) radius_r <= cfg_wdata[22:0];
      if (cfg_we && cfg_addr == CFG_THRESH) thresh_r <= cfg_wdata;
      if (state_r == ST_OUT && (!out_tvalid_r || out_tready)) begin
        total_r      <= tot_sat;
        alert_r      <= alert_r | (tot_sat > thresh_r);
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          lat1_r <= {in_tdata[30], in_tdata[30:0]};
          lon1_r <= in_tdata[62:31];
          lat2_r <= {in_tdata[93], in_tdata[93:63]};
          lon2_r <= in_tdata[125:94];
          idx_r  <= 2'd0;
        end
      end
      ST_PREP: begin
        half_r <= !idx_r[1];
        neg_r  <= neg_prep;
      end
      ST_MUL: begin
        if (mplier_r[0]) macc_r <= macc_r + mcand_r;
        mcand_r  <= mcand_r <<< 1;
        mplier_r <= mplier_r >> 1;
        cnt_r    <= cnt_r + 6'd1;
      end
      ST_RDIV0: begin
        drem_r <= dnum[63:32];
        dlo_r  <= dnum[31:0];
        cnt_r  <= '0;
      end
      ST_RDIV: begin
        drem_r <= dq ? 32'(dt - {1'b0, ddiv}) : dt[31:0];
        dlo_r  <= {dlo_r[30:0], dq};
        if (!cord_go) cnt_r <= cnt_r + 6'd1;
      end
      ST_CORD: begin
        cx_r  <= cx_s;
        cy_r  <= cy_s;
        cz_r  <= cz_s;
        cnt_r <= cnt_r + 6'd1;
      end
      ST_CDONE: begin
        if (!cvec_r && idx_r[1]) begin
          if (idx_r[0]) c2_r <= neg_r ? -cx_r : cx_r;
          else          c1_r <= neg_r ? -cx_r : cx_r;
          idx_r <= idx_r + 2'd1;
        end
      end
      ST_SQD: begin
        if (idx_r[0]) d_r <= mrnd;
        else          a_r <= mrnd;
        idx_r <= idx_r + 2'd1;
      end
      ST_H: begin
        h_r     <= h_clamp;
        sqsel_r <= 1'b0;
      end
      ST_SQRT: begin
        if (cnt_r == 6'(SQ_STEPS - 1)) begin
          // last step: the next unit launch takes over the counter
          if (!sqsel_r) begin
            sy_r    <= sqr_s;
            sqsel_r <= 1'b1;
          end
        end else begin
          sqv_r <= sqv_s;
          sqr_r <= sqr_s;
          cnt_r <= cnt_r + 6'd1;
        end
      end
      ST_SEG: seg_r <= mrf[61:30];
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tdata_r <= {7'd0, alert_r | (tot_sat > thresh_r), tot_sat, seg_r};
        end
      end
      default: ;
    endcase
    // unit launches
    if (mul_go) begin
      mcand_r  <= 80'(mul_a);
      mplier_r <= mul_b[39] ? 40'(-mul_b) : mul_b;
      mneg_r   <= mul_b[39];
      macc_r   <= '0;
      mret_r   <= mul_ret;
      cnt_r    <= '0;
    end
    if (cord_go) begin
      cx_r   <= cx0;
      cy_r   <= cy0;
      cz_r   <= cz0;
      cvec_r <= cord_vec;
      cnt_r  <= '0;
    end
    if (sq_go) begin
      sqv_r <= sq_v0;
      sqr_r <= '0;
      cnt_r <= '0;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

### hw/rtl/hvd_checker.sv
// port-level checks for the trip distance block, bound to the top level
// depends on assert_macros.svh and haversine_trip_distance
`include "assert_macros.svh"

module hvd_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [127:0] in_tdata,   // start_lat, start_lon, end_lat, end_lon, zero pad
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [87:0]  out_tdata,  // segment_cm, trip_total_cm, alert, zero pad
  input logic         cfg_we,
  input logic [1:0]   cfg_addr,
  input logic [47:0]  cfg_wdata
);

  logic [47:0] last_total_r;
  logic        alert_seen_r;
  logic        unused_ok;

  assign unused_ok = ^{in_tdata, cfg_we, cfg_addr, cfg_wdata};

  // remember the last delivered total and alert
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_total_r <= '0;
      alert_seen_r <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      last_total_r <= out_tdata[79:32];
      alert_seen_r <= alert_seen_r | out_tdata[80];
    end
  end

  `HVD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `HVD_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_tvalid && in_tready, !in_tready, "ready stayed high after a transaction")
  `HVD_ASSERT(a_total_ge_seg, clk, rst_n, out_tvalid |-> (out_tdata[79:32] >= {16'd0, out_tdata[31:0]}), "trip total below segment")
  `HVD_ASSERT(a_total_mono, clk, rst_n, out_tvalid |-> (out_tdata[79:32] >= last_total_r), "trip total went down")
  `HVD_ASSERT(a_alert_latch, clk, rst_n, (out_tvalid && alert_seen_r) |-> out_tdata[80], "alert cleared without reset")

endmodule

bind haversine_trip_distance hvd_checker u_hvd_checker (.*);

### tb/haversine_trip_distance_tb.sv
// self-checking testbench for the haversine trip distance block
// holds a bit-exact fixed-point predictor of segment, trip total and alert
// depends on hvd_pkg and haversine_trip_distance
module haversine_trip_distance_tb import hvd_pkg::*; ();

  localparam int          LIMIT_CYCLES = 5_000_000;
  localparam int          HOLD_CYCLES  = 3000;
  localparam int          DRAIN_CYCLES = 800;
  localparam logic [1:0]  CFG_SPARE0   = 2'd2;
  localparam logic [1:0]  CFG_SPARE1   = 2'd3;
  localparam logic [47:0] TOTAL_MAX    = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    logic signed [30:0] start_lat;
    logic signed [31:0] start_lon;
    logic signed [30:0] end_lat;
    logic signed [31:0] end_lon;
  } gps_pair_t;

  typedef struct {
    logic [31:0] segment_cm;
    logic [47:0] trip_total_cm;
    logic        alert;
  } trip_result_t;

  // distance predictor and queue of expected trip results
  class trip_scoreboard;
    localparam longint PI_U    = 64'd3373259426;
    localparam longint GAIN    = 652032874;
    localparam longint ONE     = 1073741824;
    localparam longint HALF    = 536870912;
    localparam longint D180    = 1800000000;
    localparam longint D360    = 64'sd3600000000;
    longint       atan_tab[24] = '{
      'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
      'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
      'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
      'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F};
    logic [22:0]  radius_m;
    logic [47:0]  threshold_cm;
    logic [47:0]  trip_total;
    logic         alert_latched;
    trip_result_t expected_q[$];
    int           errors;

    function new();
      radius_m      = RADIUS_RST;
      threshold_cm  = THRESH_RST;
      trip_total    = '0;
      alert_latched = 1'b0;
      errors        = 0;
    endfunction

    function void configure(logic [1:0] addr, logic [47:0] value);
      if (addr == CFG_RADIUS) radius_m = value[22:0];
      else if (addr == CFG_THRESH) threshold_cm = value;
    endfunction

    function longint q30_mul(longint a, longint b);
      return (a * b + HALF) >>> 30;
    endfunction

    // rounded degree units to q30 radians
    function longint to_rad(longint mag, longint unsigned div);
      longint unsigned m;
      m = mag;
      return (m * PI_U + div / 2) / div;
    endfunction

    // rotation mode, returns cosine and sine of theta in [0, pi/2]
    function void rotate(longint theta, output longint c, output longint s);
      longint x, y, z, nx;
      x = GAIN; y = 0; z = theta;
      for (int i = 0; i < CORD_N; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
        end else begin
          nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
        end
        x = nx;
      end
      c = x; s = y;
    endfunction

    // vectoring mode, atan2(y, x)
    function longint vector_angle(longint x, longint y);
      longint z, nx;
      z = 0;
      for (int i = 0; i < CORD_N; i++) begin
        if (y < 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
        end else begin
          nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
        end
        x = nx;
      end
      return z;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0; b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b; r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // sin^2 of half the difference, wrapped to [-180, 180)
    function longint half_sin_sq(longint d);
      longint r, c, s;
      r = d % D360;
      if (r >= D180) r -= D360;
      if (r < -D180) r += D360;
      if (r < 0) r = -r;
      rotate(to_rad(r, D360), c, s);
      return q30_mul(s, s);
    endfunction

    // latitudes beyond 90 degrees fold back with a negated cosine
    function longint lat_cosine(longint lat);
      longint m, c, s;
      bit neg;
      m = (lat < 0) ? -lat : lat;
      neg = 1'b0;
      if (m > D180 / 2) begin
        m = D180 - m; neg = 1'b1;
      end
      rotate(to_rad(m, D180), c, s);
      return neg ? -c : c;
    endfunction

    function void note_pair(gps_pair_t p);
      longint a, d, bc, h, ang;
      longint unsigned sy, sx, seg, tot;
      trip_result_t r;
      a  = half_sin_sq(longint'(p.end_lat) - longint'(p.start_lat));
      d  = half_sin_sq(longint'(p.end_lon) - longint'(p.start_lon));
      bc = q30_mul(lat_cosine(p.start_lat), lat_cosine(p.end_lat));
      h  = a + q30_mul(bc, d);
      if (h < 0) h = 0;
      if (h > ONE) h = ONE;
      sy  = int_sqrt(longint'(h) << 30);
      sx  = int_sqrt(longint'(ONE - h) << 30);
      ang = vector_angle(sx, sy);
      if (ang < 0) ang = 0;
      ang = ang * 2;
      seg = (longint'(radius_m) * 100 * longint'(ang) + HALF) >> 30;
      seg &= 64'hFFFF_FFFF;
      tot = longint'(trip_total) + seg;
      if (tot > longint'(TOTAL_MAX)) tot = TOTAL_MAX;
      trip_total = tot[47:0];
      if (trip_total > threshold_cm) alert_latched = 1'b1;
      r.segment_cm    = seg[31:0];
      r.trip_total_cm = trip_total;
      r.alert         = alert_latched;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [87:0] data);
      trip_result_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction: %h", data);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (data[31:0] !== e.segment_cm) begin
        $error("segment_cm: expected %0d, got %0d", e.segment_cm, data[31:0]);
        errors++;
      end
      if (data[79:32] !== e.trip_total_cm) begin
        $error("trip_total_cm: expected %0d, got %0d", e.trip_total_cm, data[79:32]);
        errors++;
      end
      if (data[80] !== e.alert) begin
        $error("alert: expected %0d, got %0d", e.alert, data[80]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [87:0]  out_tdata;
  logic         cfg_we;
  logic [1:0]   cfg_addr;
  logic [47:0]  cfg_wdata;

  trip_scoreboard sb;
  int  cycle_count;
  int  hold_left;
  bit  hold_req;
  bit  hold_done;
  int  rx_cycle;
  bit  tx_on;
  int  burst_left;

  haversine_trip_distance DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("haversine_trip_distance verification failed");
      $finish;
    end
  end

  // receiver: rotating stall patterns plus one long hold-off on request
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_req && !hold_done) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      case (rx_cycle[11:10])
        2'd0: out_tready <= 1'b1;
        2'd1: out_tready <= $urandom_range(0, 1);
        2'd2: out_tready <= (rx_cycle % 5) != 0;
        default: out_tready <= $urandom_range(0, 7) != 0;
      endcase
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // one register write, with the write enable dropped again before the task returns
  task automatic write_reg(logic [1:0] addr, logic [47:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.configure(addr, value);
    @(posedge clk);
  endtask

  // offer one pair, then maybe end the burst with a gap
  task automatic send_pair(gps_pair_t p);
    int gap;
    in_tdata  <= {2'b00, p.end_lon, p.end_lat, p.start_lon, p.start_lat};
    in_tvalid <= 1'b1;
    tx_on = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_pair(p);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 6);
      gap = $urandom_range(0, 40);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        tx_on = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop offering and wait for every expected result
  task automatic drain();
    if (tx_on) begin
      in_tvalid <= 1'b0;
      tx_on = 1'b0;
    end
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic gps_pair_t make_pair(longint slat, longint slon,
                                          longint elat, longint elon);
    gps_pair_t p;
    p.start_lat = 31'(slat); p.start_lon = 32'(slon);
    p.end_lat   = 31'(elat); p.end_lon   = 32'(elon);
    return p;
  endfunction

  // random pair: mostly valid coordinates, some full-width, some short hops
  function automatic gps_pair_t random_pair();
    gps_pair_t p;
    int sel;
    sel = $urandom_range(0, 99);
    p.start_lat = 31'(longint'($urandom_range(0, 1800000000)) - 900000000);
    p.start_lon = 32'(longint'($urandom_range(0, 32'd3600000000)) - 1800000000);
    if (sel < 45) begin
      p.end_lat = 31'(longint'($urandom_range(0, 1800000000)) - 900000000);
      p.end_lon = 32'(longint'($urandom_range(0, 32'd3600000000)) - 1800000000);
    end else if (sel < 75) begin
      p.end_lat = 31'(longint'(p.start_lat) + longint'($urandom_range(0, 200000)) - 100000);
      p.end_lon = 32'(longint'(p.start_lon) + longint'($urandom_range(0, 200000)) - 100000);
    end else begin
      p.start_lat = 31'($urandom); p.start_lon = 32'($urandom);
      p.end_lat   = 31'($urandom); p.end_lon   = 32'($urandom);
    end
    return p;
  endfunction

  initial begin
    gps_pair_t dir_q[$];
    logic [22:0] radii[5];
    sb = new();
    cycle_count = 0; rx_cycle = 0; hold_left = 0;
    hold_req = 1'b0; hold_done = 1'b0; tx_on = 1'b0; burst_left = 1;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    out_tready <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_addr   <= CFG_RADIUS;
    cfg_wdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: keep the alert clear while the extremes go through
    write_reg(CFG_THRESH, TOTAL_MAX);
    write_reg(CFG_RADIUS, 48'd7000000);
    dir_q.push_back(make_pair(0, 0, 0, 0));
    dir_q.push_back(make_pair(0, 0, 0, 1800000000));
    dir_q.push_back(make_pair(0, -1800000000, 0, 1800000000));
    dir_q.push_back(make_pair(900000000, 0, -900000000, 0));
    dir_q.push_back(make_pair(-900000000, 123, 900000000, -456));
    dir_q.push_back(make_pair(1073741823, 0, -1073741824, 0));
    dir_q.push_back(make_pair(-1073741824, -2147483648, 1073741823, 2147483647));
    dir_q.push_back(make_pair(950000000, 100000000, 850000000, -100000000));
    dir_q.push_back(make_pair(0, -2147483648, 0, 2147483647));
    dir_q.push_back(make_pair(0, 2147483647, 0, -2147483648));
    dir_q.push_back(make_pair(0, 0, 0, 1));
    dir_q.push_back(make_pair(0, 0, 1, 0));
    dir_q.push_back(make_pair(450000000, 0, 450000000, -1799999999));
    dir_q.push_back(make_pair(-300000000, 900000000, 300000000, -900000000));
    dir_q.push_back(make_pair(899999999, 1799999999, -899999999, -1799999999));
    dir_q.push_back(make_pair(523456789, 134567890, 523456789, 134567990));
    dir_q.push_back(make_pair(-1, -1, 0, 0));
    dir_q.push_back(make_pair(0, 1799999999, 0, -1800000000));
    foreach (dir_q[i]) send_pair(dir_q[i]);
    drain();

    // alert: total equal to threshold stays clear, a following hop above it latches
    write_reg(CFG_THRESH, sb.trip_total);
    send_pair(make_pair(100, 200, 100, 200));
    send_pair(make_pair(0, 0, 1000000, 0));
    drain();

    // random phases over a spread of radius settings
    radii = '{23'd6000000, 23'd8388607, 23'd0, 23'd6371000, 23'd7000000};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_SPARE0, 48'({$urandom, $urandom}));
      write_reg(CFG_SPARE1, 48'({$urandom, $urandom}));
      write_reg(CFG_RADIUS, (ph == 4) ? 48'($urandom_range(6000000, 7000000))
                                      : 48'(radii[ph]));
      case (ph)
        0: write_reg(CFG_THRESH, 48'd0);
        1: write_reg(CFG_THRESH, 48'({$urandom, $urandom}));
        default: write_reg(CFG_THRESH, 48'(sb.trip_total + $urandom_range(0, 1000000000)));
      endcase
      for (int n = 0; n < 175; n++) begin
        if (ph == 1 && n == 20) hold_req = 1'b1;
        send_pair(random_pair());
      end
      drain();
    end

    // end of run
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("haversine_trip_distance verification clean");
    end else begin
      $display("haversine_trip_distance verification failed");
    end
    $finish;
  end

endmodule
